>>> src/ald_pkg.sv
// ============================================================================
// ald_pkg: shared types and constants of the array linked deque
// Holds the slot geometry, opcode and status codes, and the result record
// that passes from the list core to the output register.
// ============================================================================
package ald_pkg;

    // Slot geometry and field widths.
    localparam int SLOTS   = 32;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 6;

    typedef logic [IDX_W-1:0]   t_slot;
    typedef logic [CNT_W-1:0]   t_count;
    typedef logic [VALUE_W-1:0] t_value;

    // Operation requested by one item.
    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_opcode;

    // Outcome reported with each result item.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Result of one item, as produced by the list core.
    typedef struct packed {
        t_status status;
        t_value  popped_value;
        t_count  entry_count;
    } t_result;

endpackage

>>> src/ald_free_enc.sv
// ============================================================================
// ald_free_enc: lowest free slot finder
// Priority encoder over the slot in-use bits. Reports the lowest slot whose
// bit is clear and whether any such slot exists.
// ============================================================================
module ald_free_enc (
    input  logic [ald_pkg::SLOTS-1:0] i_used,
    output ald_pkg::t_slot            o_free_slot,
    output logic                      o_free_found
);
    import ald_pkg::*;

    // Scan from the top down so that the lowest free slot wins.
    always_comb begin
        o_free_slot  = '0;
        o_free_found = 1'b0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_used[i]) begin
                o_free_slot  = t_slot'(i);
                o_free_found = 1'b1;
            end
        end
    end

endmodule

>>> src/ald_list.sv
// ============================================================================
// ald_list: linked list core
// Keeps the slot arrays, head and tail pointers and the entry count, and
// applies at most one push or pop per accepted item.
// ============================================================================
module ald_list (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ald_pkg::t_opcode   i_opcode,
    input  ald_pkg::t_value    i_value,
    output ald_pkg::t_result   o_result
);
    import ald_pkg::*;

    // Slot storage. Only slots in use, and their links, are ever read.
    t_value     r_slot_value [SLOTS];
    t_slot      r_slot_next  [SLOTS];
    t_slot      r_slot_prev  [SLOTS];
    logic [SLOTS-1:0] r_slot_used;
    logic [SLOTS-1:0] n_slot_used;

    t_slot  r_head, n_head;
    t_slot  r_tail, n_tail;
    t_count r_size, n_size;

    t_slot  free_slot;
    logic   free_found;
    logic   is_push;
    logic   is_back;
    logic   list_empty;
    logic   do_push;
    logic   do_pop;
    t_slot  end_slot;

    ald_free_enc u_free_enc (
        .i_used       (r_slot_used),
        .o_free_slot  (free_slot),
        .o_free_found (free_found)
    );

    // Decode the operation.
    always_comb begin
        unique case (i_opcode)
            OP_PUSH_BACK:  begin is_push = 1'b1; is_back = 1'b1; end
            OP_PUSH_FRONT: begin is_push = 1'b1; is_back = 1'b0; end
            OP_POP_BACK:   begin is_push = 1'b0; is_back = 1'b1; end
            OP_POP_FRONT:  begin is_push = 1'b0; is_back = 1'b0; end
            default:       begin is_push = 1'b0; is_back = 1'b0; end
        endcase
    end

    assign list_empty = (r_size == '0);
    assign do_push    = i_accept && is_push && free_found;
    assign do_pop     = i_accept && !is_push && !list_empty;
    assign end_slot   = is_back ? r_tail : r_head;

    // Next values of the pointers, the count and the in-use bits.
    always_comb begin
        n_slot_used = r_slot_used;
        n_head      = r_head;
        n_tail      = r_tail;
        n_size      = r_size;
        if (do_push) begin
            n_slot_used[free_slot] = 1'b1;
            n_size = r_size + t_count'(1);
            if (list_empty) begin
                n_head = free_slot;
                n_tail = free_slot;
            end else if (is_back) begin
                n_tail = free_slot;
            end else begin
                n_head = free_slot;
            end
        end
        if (do_pop) begin
            n_slot_used[end_slot] = 1'b0;
            n_size = r_size - t_count'(1);
            // With one entry left the pointers go stale until the next push.
            if (r_size > t_count'(1)) begin
                if (is_back) begin
                    n_tail = r_slot_prev[r_tail];
                end else begin
                    n_head = r_slot_next[r_head];
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_used <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_size      <= '0;
        end else begin
            r_slot_used <= n_slot_used;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_size      <= n_size;
        end
    end

    // Slot payload and links. The tail or head is in use, so it never
    // collides with the free slot being linked in.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot_value[free_slot] <= i_value;
            if (list_empty) begin
                r_slot_next[free_slot] <= free_slot;
                r_slot_prev[free_slot] <= free_slot;
            end else if (is_back) begin
                r_slot_next[r_tail]    <= free_slot;
                r_slot_prev[free_slot] <= r_tail;
                r_slot_next[free_slot] <= free_slot;
            end else begin
                r_slot_prev[r_head]    <= free_slot;
                r_slot_next[free_slot] <= r_head;
                r_slot_prev[free_slot] <= free_slot;
            end
        end
    end

    // Result of the current item.
    always_comb begin
        o_result.status       = ST_DONE;
        o_result.popped_value = '0;
        o_result.entry_count  = n_size;
        if (is_push && !free_found) begin
            o_result.status = ST_FULL;
        end else if (!is_push && list_empty) begin
            o_result.status = ST_EMPTY;
        end
        if (do_pop) begin
            o_result.popped_value = r_slot_value[end_slot];
        end
    end

endmodule

>>> src/array_linked_deque.sv
// ============================================================================
// array_linked_deque: deque built on a doubly linked list in slot arrays
// Pushes and pops at either end, one result item per input item.
// ============================================================================
// Usage:
//   Input channel: i_valid with i_opcode and i_value; the block answers with
//   o_stall. An item is taken at a clock edge with i_valid high and o_stall
//   low. Opcodes push back, push front, pop back and pop front.
//   Output channel: o_valid with o_status, o_popped_value and o_entry_count;
//   the receiver answers with i_stall. A result is taken at a clock edge with
//   o_valid high and i_stall low.
//   Each result is registered and shown in the cycle after its item is taken.
//   Throughput: one item per cycle unless stalled. The free-slot priority
//   encoder over the 32 in-use bits and the link update finish in the same
//   cycle. A push onto a full list reports full and changes nothing; a pop
//   from an empty list reports empty and changes nothing.
//   Reset (synchronous, active low) empties the list and drops any result.
//   While the receiver stalls, the result holds and o_stall rises, so no
//   further item is taken until the result leaves.
// ============================================================================
module array_linked_deque (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_opcode,
    input  logic signed [31:0]  i_value,
    output logic                o_stall,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic signed [31:0]  o_popped_value,
    output logic [5:0]          o_entry_count,
    input  logic                i_stall
);
    import ald_pkg::*;

    logic    in_accept;
    t_result core_result;
    t_result r_result;
    logic    r_valid, n_valid;

    // The output register may be refilled in the cycle it empties.
    assign o_stall   = r_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    ald_list u_list (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_opcode (t_opcode'(i_opcode)),
        .i_value  (t_value'(i_value)),
        .o_result (core_result)
    );

    // Output valid flag.
    always_comb begin
        if (in_accept) begin
            n_valid = 1'b1;
        end else if (i_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Result payload, loaded with each accepted item.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= core_result;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_result.status;
    assign o_popped_value = r_result.popped_value;
    assign o_entry_count  = r_result.entry_count;

endmodule

>>> src/ald_checker.sv
// ============================================================================
// ald_checker: port-level checks of the array linked deque
// Watches the top level's ports and checks result timing and the
// consistency of status, popped value and entry count.
// ============================================================================
module ald_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic [1:0]         o_status,
    input logic signed [31:0] o_popped_value,
    input logic [5:0]         o_entry_count,
    input logic               i_stall
);
    import ald_pkg::*;

    // A stalled result stays on the port.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // Every taken item shows its result in the next cycle.
    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_valid)
        else $error("no result one cycle after an item");

    // A full report means every slot is in use.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_entry_count == CNT_W'(SLOTS))
        else $error("full reported with free slots");

    // An empty report means no entries and no popped data.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |->
            o_entry_count == '0 && o_popped_value == '0)
        else $error("empty reported on a non-empty list");

endmodule

bind array_linked_deque ald_checker u_ald_checker (.*);

>>> tb/sv/tb_array_linked_deque.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_array_linked_deque: self-checking testbench of the array linked deque
// Drives push and pop items at both ends through the valid/stall input
// channel. A behavioral copy of the slot list predicts each result item.
// Results are compared field by field as they leave the output channel.
// A short directed table comes first, including a fill to full. Random
// bursts follow that fill, drain and mix the list, under four idling phases.
// ============================================================================
module tb_array_linked_deque;

    import ald_pkg::*;

    // Burst kinds of the random part.
    localparam int BURST_FILL  = 0;
    localparam int BURST_DRAIN = 1;
    localparam int BURST_GROW  = 2;
    localparam int BURST_MIX   = 3;

    localparam int ITEMS_PER_PHASE = 250;
    localparam int SHOW_LIMIT      = 10;

    // One row of the directed table. A row may repeat its operation.
    typedef struct packed {
        t_opcode op;
        t_value  val;
        int      reps;
        bit      rnd_val;
        bit      typed;
        t_status st;
        t_value  pv;
        t_count  cnt;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic [1:0]        i_opcode;
    logic signed [31:0] i_value;
    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_status;
    logic signed [31:0] o_popped_value;
    logic [5:0]        o_entry_count;
    logic              i_stall;

    // Shadow copy of the slot list.
    t_value  lst_value [SLOTS];
    t_slot   lst_next  [SLOTS];
    t_slot   lst_prev  [SLOTS];
    bit      lst_used  [SLOTS];
    t_slot   lst_head;
    t_slot   lst_tail;
    t_count  lst_count;

    t_result  pending_results [$];
    t_dir_row dir_rows [$];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int full_count   = 0;
    int empty_count  = 0;

    array_linked_deque uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_popped_value (o_popped_value),
        .o_entry_count  (o_entry_count),
        .i_stall        (i_stall)
    );

    // Free-running clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one operation to the shadow list and returns its result item.
    function automatic t_result predict_deque_op(input t_opcode op, input t_value val);
        t_result r;
        int      free_idx;
        t_slot   s;
        r.status       = ST_DONE;
        r.popped_value = '0;
        if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
            // Lowest free slot wins, as in a priority encoder.
            free_idx = SLOTS;
            for (int i = SLOTS - 1; i >= 0; i--) begin
                if (!lst_used[i]) begin
                    free_idx = i;
                end
            end
            if (free_idx == SLOTS) begin
                r.status = ST_FULL;
            end else begin
                s = t_slot'(free_idx);
                lst_value[s] = val;
                lst_used[s]  = 1'b1;
                if (lst_count == 0) begin
                    lst_head    = s;
                    lst_tail    = s;
                    lst_next[s] = s;
                    lst_prev[s] = s;
                end else if (op == OP_PUSH_BACK) begin
                    lst_next[lst_tail] = s;
                    lst_prev[s]        = lst_tail;
                    lst_next[s]        = s;
                    lst_tail           = s;
                end else begin
                    lst_prev[lst_head] = s;
                    lst_next[s]        = lst_head;
                    lst_prev[s]        = s;
                    lst_head           = s;
                end
                lst_count++;
            end
        end else if (lst_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            s = (op == OP_POP_BACK) ? lst_tail : lst_head;
            r.popped_value = lst_value[s];
            lst_used[s]    = 1'b0;
            // Head and tail go stale once the last entry leaves.
            if (lst_count > 1) begin
                if (op == OP_POP_BACK) begin
                    lst_tail = lst_prev[s];
                end else begin
                    lst_head = lst_next[s];
                end
            end
            lst_count--;
        end
        r.entry_count = lst_count;
        return r;
    endfunction

    // Random value with the extremes and -1 mixed in.
    function automatic t_value rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_opcode rand_push();
        return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    endfunction

    function automatic t_opcode rand_pop();
        return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
    endfunction

    task automatic add_row(input t_opcode op, input t_value val, input int reps,
                           input bit rnd_val, input bit typed, input t_status st,
                           input t_value pv, input t_count cnt);
        t_dir_row row;
        row.op      = op;
        row.val     = val;
        row.reps    = reps;
        row.rnd_val = rnd_val;
        row.typed   = typed;
        row.st      = st;
        row.pv      = pv;
        row.cnt     = cnt;
        dir_rows.push_back(row);
    endtask

    // Sends one item, with optional idle cycles ahead of it, and records the
    // expected result once the block takes it.
    task automatic send_item(input t_opcode op, input t_value val, input bit typed,
                             input t_result typed_res);
        t_result r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_opcode <= op;
        i_value  <= val;
        @(posedge i_clk);
        while (o_stall !== 1'b0) begin
            @(posedge i_clk);
        end
        r = predict_deque_op(op, val);
        if (r.status == ST_FULL) begin
            full_count++;
        end
        if (r.status == ST_EMPTY) begin
            empty_count++;
        end
        pending_results.push_back(typed ? typed_res : r);
        items_sent++;
    endtask

    // Result side: checks each accepted result item and stalls at random.
    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT) begin
                    $display("ERROR: unexpected result: status=%0d popped=%0d count=%0d",
                             o_status, o_popped_value, o_entry_count);
                end
            end else begin
                exp_r = pending_results.pop_front();
                if (o_status !== exp_r.status ||
                    o_popped_value !== exp_r.popped_value ||
                    o_entry_count !== exp_r.entry_count) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT) begin
                        $display({"ERROR: result %0d: expected status=%0d popped=%0d ",
                                  "count=%0d, got status=%0d popped=%0d count=%0d"},
                                 results_seen, exp_r.status,
                                 $signed(exp_r.popped_value), exp_r.entry_count,
                                 o_status, o_popped_value, o_entry_count);
                    end
                end
            end
            results_seen++;
        end
        i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end

    // Main stimulus.
    initial begin
        t_result want;
        t_result none;
        int      phase_items;
        int      kind;
        int      len;

        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_opcode = OP_PUSH_BACK;
        i_value  = '0;
        i_stall  = 1'b0;
        none     = '0;

        for (int i = 0; i < SLOTS; i++) begin
            lst_value[i] = '0;
            lst_next[i]  = '0;
            lst_prev[i]  = '0;
            lst_used[i]  = 1'b0;
        end
        lst_head  = '0;
        lst_tail  = '0;
        lst_count = '0;

        // Directed table: pops on empty, extremes at both ends, a front push
        // into an empty list popped from the back, then a fill to full.
        add_row(OP_POP_BACK,   32'h1234_5678, 1, 0, 1, ST_EMPTY, '0, 0);
        add_row(OP_POP_FRONT,  32'hFFFF_FFFF, 1, 0, 1, ST_EMPTY, '0, 0);
        add_row(OP_PUSH_BACK,  32'h7FFF_FFFF, 1, 0, 1, ST_DONE, '0, 1);
        add_row(OP_PUSH_FRONT, 32'h8000_0000, 1, 0, 1, ST_DONE, '0, 2);
        add_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 1, 0, 1, ST_DONE, '0, 3);
        add_row(OP_PUSH_FRONT, 32'h0000_0000, 1, 0, 1, ST_DONE, '0, 4);
        add_row(OP_POP_BACK,   32'h5555_5555, 1, 0, 1, ST_DONE, 32'hFFFF_FFFF, 3);
        add_row(OP_POP_FRONT,  32'hAAAA_AAAA, 1, 0, 1, ST_DONE, 32'h0000_0000, 2);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1, 0, 1, ST_DONE, 32'h8000_0000, 1);
        add_row(OP_POP_BACK,   32'h0000_0000, 1, 0, 1, ST_DONE, 32'h7FFF_FFFF, 0);
        add_row(OP_POP_BACK,   32'h0000_0000, 1, 0, 1, ST_EMPTY, '0, 0);
        add_row(OP_PUSH_FRONT, 32'hA5A5_A5A5, 1, 0, 1, ST_DONE, '0, 1);
        add_row(OP_POP_BACK,   32'h0000_0000, 1, 0, 1, ST_DONE, 32'hA5A5_A5A5, 0);
        add_row(OP_PUSH_FRONT, 32'h5A5A_5A5A, 1, 0, 0, ST_DONE, '0, 0);
        add_row(OP_PUSH_BACK,  32'h0000_0002, 1, 0, 0, ST_DONE, '0, 0);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1, 0, 0, ST_DONE, '0, 0);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1, 0, 0, ST_DONE, '0, 0);
        add_row(OP_PUSH_BACK,  32'h0000_0000, SLOTS, 1, 0, ST_DONE, '0, 0);
        add_row(OP_PUSH_FRONT, 32'h0BAD_0BAD, 1, 0, 1, ST_FULL, '0, t_count'(SLOTS));
        add_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 1, 0, 1, ST_FULL, '0, t_count'(SLOTS));
        add_row(OP_POP_FRONT,  32'h0000_0000, 1, 0, 0, ST_DONE, '0, 0);
        add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1, 0, 0, ST_DONE, '0, 0);
        add_row(OP_POP_BACK,   32'h0000_0000, 1, 0, 0, ST_DONE, '0, 0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                want.status       = dir_rows[r].st;
                want.popped_value = dir_rows[r].pv;
                want.entry_count  = dir_rows[r].cnt;
                send_item(dir_rows[r].op,
                          dir_rows[r].rnd_val ? rand_value() : dir_rows[r].val,
                          dir_rows[r].typed, want);
            end
        end

        // Random bursts under four idling phases: none, sender idle,
        // receiver stalling, both.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 85; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 85; end
                default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
            endcase
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE) begin
                kind = $urandom_range(BURST_FILL, BURST_MIX);
                len  = (kind == BURST_FILL || kind == BURST_DRAIN) ? SLOTS + 4 : 24;
                for (int k = 0; k < len; k++) begin
                    case (kind)
                        BURST_FILL:  send_item(rand_push(), rand_value(), 0, none);
                        BURST_DRAIN: send_item(rand_pop(), rand_value(), 0, none);
                        BURST_GROW: begin
                            send_item(($urandom_range(0, 99) < 75) ? rand_push() : rand_pop(),
                                      rand_value(), 0, none);
                        end
                        default: begin
                            send_item(t_opcode'($urandom_range(OP_PUSH_BACK, OP_POP_FRONT)),
                                      rand_value(), 0, none);
                        end
                    endcase
                end
                phase_items += len;
            end
            // Hold off the sender until every result of this phase is back.
            i_valid <= 1'b0;
            while (pending_results.size() != 0) begin
                @(posedge i_clk);
            end
        end

        // Drain and wait for any stray result.
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Covered %0d items at both ends under four idling phases, %0d results checked.",
                 items_sent, results_seen);
        $display("Full was reported %0d times and empty %0d times; %0d mismatches.",
                 full_count, empty_count, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
